[rtl/core/mmh_pkg.sv]
// shared types, constants and helper functions of the murmur64a stream hasher
// no dependencies; imported by every module of the block
package mmh_pkg;

    // mixing constants
    localparam logic [63:0] MIX_MUL    = 64'hc6a4a7935bd1e995;
    localparam int          MIX_SHIFT  = 47;
    localparam logic [63:0] SEED_RESET = 64'h00000000c70f6907;

    // configuration register indexes
    localparam logic REG_HASH_SEED = 1'b0;

    // input payload layout
    localparam int LEN_W   = 32;
    localparam int WORD_W  = 64;
    localparam int COUNT_W = 4;
    localparam int WORD_BYTES = 8;

    // front controller states
    typedef enum logic [2:0] {
        F_IDLE,
        F_LEN,
        F_K1,
        F_K2,
        F_PUSH
    } front_state_t;

    // back controller states
    typedef enum logic [1:0] {
        B_IDLE,
        B_FOLD,
        B_FIN,
        B_OUT
    } back_state_t;

    // one prepared item handed from the front to the back
    typedef struct packed {
        logic        first;
        logic        last;
        logic        fold;
        logic [63:0] len_prod;
        logic [63:0] key;
    } entry_t;

    // shift-xor step used in key mixing and finalization
    function automatic logic [63:0] fin_mix(input logic [63:0] x);
        fin_mix = x ^ (x >> MIX_SHIFT);
    endfunction

endpackage

[rtl/core/mmh_mul.sv]
// pipelined multiply by the mixing constant, low 64 bits of the product
// uses mmh_pkg for the constant; built from three 32x32 partial products
module mmh_mul (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] operand,
    output logic        done,
    output logic [63:0] result
);
    import mmh_pkg::*;

    logic        s1_valid_reg;
    logic        done_reg;
    logic [63:0] p0_reg;
    logic [31:0] p1_reg;
    logic [31:0] p2_reg;
    logic [63:0] result_reg;

    logic [63:0] p0_full;
    logic [31:0] p1_low;
    logic [31:0] p2_low;
    logic [31:0] cross_sum;

    // partial products: low by low, and the low halves of the two cross terms
    assign p0_full = operand[31:0]  * MIX_MUL[31:0];
    assign p1_low  = operand[63:32] * MIX_MUL[31:0];
    assign p2_low  = operand[31:0]  * MIX_MUL[63:32];
    assign cross_sum = p1_reg + p2_reg;

    // control pipe
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end else begin
            s1_valid_reg <= start;
            done_reg     <= s1_valid_reg;
        end
    end

    // product registers, result holds until the next start
    always_ff @(posedge aclk) begin
        if (start) begin
            p0_reg <= p0_full;
            p1_reg <= p1_low;
            p2_reg <= p2_low;
        end
        if (s1_valid_reg) begin
            result_reg <= p0_reg + {cross_sum, 32'h0};
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

[rtl/core/mmh_queue.sv]
// small fifo of prepared items between the front and the back
// uses mmh_pkg for the entry type
module mmh_queue #(
    parameter int DEPTH = 2
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  mmh_pkg::entry_t push_data,
    output logic           full,
    input  logic           pop,
    output mmh_pkg::entry_t head,
    output logic           empty
);
    import mmh_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    entry_t          slot_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head  = slot_reg[rd_ptr_reg];
    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);

endmodule

[rtl/core/mmh_front.sv]
// front end: accepts input transactions, classifies the word and premixes it
// uses mmh_pkg and one mmh_mul for length seeding and key mixing
module mmh_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic               s_tuser,
    input  logic               s_tlast,
    input  logic [103:0]       s_tdata,
    output logic               q_push,
    output mmh_pkg::entry_t    q_data,
    input  logic               q_full
);
    import mmh_pkg::*;

    front_state_t        state_reg, state_next;
    logic                first_reg, first_next;
    logic                last_reg, last_next;
    logic                fold_reg, fold_next;
    logic                full_reg, full_next;
    logic [63:0]         key_reg, key_next;
    logic [63:0]         len_prod_reg, len_prod_next;

    logic                accept;
    logic [LEN_W-1:0]    in_len;
    logic [WORD_W-1:0]   in_word;
    logic [COUNT_W-1:0]  in_count;
    logic                in_full;
    logic [63:0]         tail_word;

    logic                mul_start;
    logic [63:0]         mul_a;
    logic                mul_done;
    logic [63:0]         mul_res;

    mmh_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .operand (mul_a),
        .done    (mul_done),
        .result  (mul_res)
    );

    // unpack the payload
    assign in_len   = s_tdata[31:0];
    assign in_word  = s_tdata[95:32];
    assign in_count = s_tdata[99:96];
    assign in_full  = (in_count >= COUNT_W'(WORD_BYTES));
    assign s_tready = (state_reg == F_IDLE);
    assign accept   = s_tvalid && s_tready;

    // keep only the valid bytes of a tail word
    always_comb begin
        for (int i = 0; i < WORD_BYTES; i++) begin
            tail_word[8*i +: 8] = (COUNT_W'(i) < in_count) ? in_word[8*i +: 8] : 8'h00;
        end
    end

    // sequencer over the shared multiplier
    always_comb begin
        state_next    = state_reg;
        first_next    = first_reg;
        last_next     = last_reg;
        fold_next     = fold_reg;
        full_next     = full_reg;
        key_next      = key_reg;
        len_prod_next = len_prod_reg;
        mul_start     = 1'b0;
        mul_a         = key_reg;
        q_push        = 1'b0;
        unique case (state_reg)
            F_IDLE: begin
                if (accept) begin
                    first_next = s_tuser;
                    last_next  = s_tlast;
                    fold_next  = (in_count != '0);
                    full_next  = in_full;
                    key_next   = in_full ? in_word : tail_word;
                    if (s_tuser) begin
                        mul_start  = 1'b1;
                        mul_a      = {32'h0, in_len};
                        state_next = F_LEN;
                    end else if (in_full) begin
                        mul_start  = 1'b1;
                        mul_a      = in_word;
                        state_next = F_K1;
                    end else begin
                        state_next = F_PUSH;
                    end
                end
            end
            F_LEN: begin
                if (mul_done) begin
                    len_prod_next = mul_res;
                    if (full_reg) begin
                        mul_start  = 1'b1;
                        mul_a      = key_reg;
                        state_next = F_K1;
                    end else begin
                        state_next = F_PUSH;
                    end
                end
            end
            F_K1: begin
                if (mul_done) begin
                    mul_start  = 1'b1;
                    mul_a      = fin_mix(mul_res);
                    state_next = F_K2;
                end
            end
            F_K2: begin
                if (mul_done) begin
                    key_next   = mul_res;
                    state_next = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!q_full) begin
                    q_push     = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // item payload registers
    always_ff @(posedge aclk) begin
        first_reg    <= first_next;
        last_reg     <= last_next;
        fold_reg     <= fold_next;
        full_reg     <= full_next;
        key_reg      <= key_next;
        len_prod_reg <= len_prod_next;
    end

    assign q_data.first    = first_reg;
    assign q_data.last     = last_reg;
    assign q_data.fold     = fold_reg;
    assign q_data.len_prod = len_prod_reg;
    assign q_data.key      = key_reg;

endmodule

[rtl/core/mmh_back.sv]
// back end: folds prepared keys into the running hash, finalizes, holds the result
// uses mmh_pkg and one mmh_mul for the state recurrence and finalization
module mmh_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic [63:0]     hash_seed,
    input  mmh_pkg::entry_t q_head,
    input  logic            q_empty,
    output logic            q_pop,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [63:0]     m_tdata
);
    import mmh_pkg::*;

    back_state_t  state_reg, state_next;
    logic [63:0]  running_reg, running_next;
    logic         last_reg, last_next;
    logic         out_valid_reg, out_valid_next;
    logic [63:0]  out_hash_reg, out_hash_next;

    logic [63:0]  h_start;
    logic         mul_start;
    logic [63:0]  mul_a;
    logic         mul_done;
    logic [63:0]  mul_res;

    mmh_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .operand (mul_a),
        .done    (mul_done),
        .result  (mul_res)
    );

    // a first item reseeds the state
    assign h_start = q_head.first ? (hash_seed ^ q_head.len_prod) : running_reg;

    // fold, finalize and output control
    always_comb begin
        state_next     = state_reg;
        running_next   = running_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_hash_next  = out_hash_reg;
        mul_start      = 1'b0;
        mul_a          = h_start;
        q_pop          = 1'b0;
        unique case (state_reg)
            B_IDLE: begin
                if (!q_empty) begin
                    q_pop     = 1'b1;
                    last_next = q_head.last;
                    if (q_head.fold) begin
                        mul_start  = 1'b1;
                        mul_a      = h_start ^ q_head.key;
                        state_next = B_FOLD;
                    end else begin
                        running_next = h_start;
                        if (q_head.last) begin
                            mul_start  = 1'b1;
                            mul_a      = fin_mix(h_start);
                            state_next = B_FIN;
                        end
                    end
                end
            end
            B_FOLD: begin
                if (mul_done) begin
                    running_next = mul_res;
                    if (last_reg) begin
                        mul_start  = 1'b1;
                        mul_a      = fin_mix(mul_res);
                        state_next = B_FIN;
                    end else begin
                        state_next = B_IDLE;
                    end
                end
            end
            B_FIN: begin
                if (mul_done) begin
                    state_next = B_OUT;
                end
            end
            B_OUT: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_hash_next  = fin_mix(mul_res);
                    state_next     = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            running_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            running_reg   <= running_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        last_reg     <= last_next;
        out_hash_reg <= out_hash_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_hash_reg;

endmodule

[rtl/core/murmur64a_stream_hasher_unit.sv]
// top level of the murmur64a stream hasher: config registers, front, queue, back
// depends on mmh_pkg, mmh_mul, mmh_queue, mmh_front and mmh_back
//
// Computes the 64-bit MurmurHash64A of messages streamed as little-endian 64-bit
// words. The first transaction of a message (s_tuser high) carries the byte length
// and seeds the hash with the hash_seed register; s_tlast closes the message and one
// result transaction with the hash follows on m_. The front end takes one item at
// a time and runs it through its own constant multiplier: the length product of a
// first item and the two multiplies of full-word mixing, between an accept step and
// a queue-push step. The back end folds each item that holds data into the state,
// finalizes on a last item, and works in parallel through a QUEUE_DEPTH-entry
// queue. A finished hash sits in an output register so the front keeps accepting
// while the result waits. hash_seed sits at byte address 0 of the 64-bit APB port
// and resets to 0xc70f6907.
module murmur64a_stream_hasher_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic          aclk,
    input  logic          aresetn,
    // input channel
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [103:0]  s_tdata,   // message_length[31:0], data_word[95:32],
                                     // byte_count[99:96], zero pad[103:100]
    input  logic          s_tuser,   // first_word
    input  logic          s_tlast,   // last_word
    // result channel
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [63:0]   m_tdata,   // hash_value[63:0]
    // configuration port
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [63:0]   pwdata,
    output logic [63:0]   prdata,
    output logic          pready
);
    import mmh_pkg::*;

    logic [63:0] seed_reg, seed_next;
    logic        cfg_write;

    logic        q_push;
    logic        q_pop;
    logic        q_full;
    logic        q_empty;
    entry_t      q_in;
    entry_t      q_head;

    // register file
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        seed_next = seed_reg;
        if (cfg_write && (paddr[3] == REG_HASH_SEED)) begin
            seed_next = pwdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= SEED_RESET;
        end else begin
            seed_reg <= seed_next;
        end
    end

    assign prdata = (paddr[3] == REG_HASH_SEED) ? seed_reg : 64'h0;

    mmh_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .s_tdata  (s_tdata),
        .q_push   (q_push),
        .q_data   (q_in),
        .q_full   (q_full)
    );

    mmh_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    mmh_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .hash_seed (seed_reg),
        .q_head    (q_head),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

`ifndef SYNTHESIS
    // front never writes into a full queue
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full)
        else $error("queue push while full");

    // back never reads an empty queue
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_empty)
        else $error("queue pop while empty");

    // a lone push into an empty queue makes it visible to the back
    a_push_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_push && q_empty && !q_pop) |=> !q_empty)
        else $error("pushed entry lost");
`endif

endmodule
